// ===== rtl/segment_endpoint_bridger_core_macros.svh =====
// ----------------------------------------------------------------------------
// segment endpoint bridger assertion macros
// shared concurrent assertion helpers, empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ENDPOINT_BRIDGER_CORE_MACROS_SVH
`define SEGMENT_ENDPOINT_BRIDGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SEB_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("seb assertion failed");
`define SEB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("seb assertion failed");
`define SEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("seb assertion failed");
`else
`define SEB_ASSERT(label, expr)
`define SEB_ASSERT_IMPL(label, ante, cons)
`define SEB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/seb_pkg.sv =====
// ----------------------------------------------------------------------------
// seb_pkg
// shared constants, types and helpers of the segment endpoint bridger
// ----------------------------------------------------------------------------
package seb_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 12;
    localparam int THR_BITS     = 16;
    localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int HIT_W        = $clog2(MAX_SEGMENTS);
    localparam int SEG_W        = 4 * COORD_BITS;
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int DIST_W       = 2 * COORD_BITS + 1;
    localparam int MAX_RESULTS  = MAX_SEGMENTS - 1;
    localparam int GAP_CEILING  = 50000;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd1440;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_seg;

    typedef struct packed {
        t_coord fx;
        t_coord fy;
        t_coord tx;
        t_coord ty;
        logic   last;
    } t_bridge;

    typedef struct packed {
        logic              start;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_end;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic busy;
    } t_stat;

    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/seb_ram.sv =====
// ----------------------------------------------------------------------------
// seb_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module seb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/seb_ctrl.sv =====
// ----------------------------------------------------------------------------
// seb_ctrl
// sequencer: input handshake, store fill count and scan of stored segments
// ----------------------------------------------------------------------------
`include "segment_endpoint_bridger_core_macros.svh"

module seb_ctrl import seb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_seg_valid,
    output logic  o_seg_ready,
    input  logic  i_new_set,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              accept;
    logic              room;
    logic [CNT_W-1:0]  eff_cnt;

    assign o_seg_ready = (r_state == ST_IDLE);
    assign accept      = i_seg_valid && o_seg_ready;
    assign eff_cnt     = i_new_set ? '0 : r_count;
    assign room        = (eff_cnt < CNT_W'(MAX_SEGMENTS));

    always_comb begin
        o_cmd.start   = accept;
        o_cmd.wr_en   = accept && room;
        o_cmd.wr_addr = eff_cnt[ADDR_W-1:0];
        o_cmd.issue   = (r_state == ST_SCAN) && i_stat.adv;
        o_cmd.rd_addr = r_idx;
        o_cmd.rd_end  = (CNT_W'(r_idx) == (r_limit - CNT_W'(1)));
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_limit = r_limit;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_count = eff_cnt + CNT_W'(room);
                    n_limit = eff_cnt;
                    n_idx   = '0;
                    if (eff_cnt != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (o_cmd.issue) begin
                    n_idx = r_idx + ADDR_W'(1);
                    if (o_cmd.rd_end) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_limit <= n_limit;
        r_idx   <= n_idx;
    end

    `SEB_ASSERT_IMPL(a_idx_in_range, r_state == ST_SCAN, CNT_W'(r_idx) < r_limit)
    `SEB_ASSERT(a_count_bounded, r_count <= CNT_W'(MAX_SEGMENTS))
    `SEB_ASSERT_NEXT(a_new_set_restart, accept && i_new_set, r_count == CNT_W'(1))

endmodule

// ===== rtl/seb_dp.sv =====
// ----------------------------------------------------------------------------
// seb_dp
// datapath: segment store, distance pipeline, pick logic and result buffer
// ----------------------------------------------------------------------------
module seb_dp import seb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  t_seg                i_seg,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_wdata,
    output logic                o_bridge_valid,
    input  logic                i_bridge_ready,
    output t_bridge             o_bridge
);

    logic [THR_BITS-1:0] r_thr;
    t_seg                r_new;
    t_seg                ram_q;
    logic [SEG_W-1:0]    ram_rdata;
    logic                adv;

    logic                r_v0, r_e0;
    logic                r_v1, r_e1;
    logic                r_v2, r_e2;
    logic                r_v3, r_e3;
    t_seg                r_s1, r_s2, r_s3;
    t_coord              r_adx [4];
    t_coord              r_ady [4];
    logic [SQ_W-1:0]     r_sqx [4];
    logic [SQ_W-1:0]     r_sqy [4];
    logic [DIST_W-1:0]   r_d   [4];
    t_coord              fx [4];
    t_coord              fy [4];
    t_coord              tx [4];
    t_coord              ty [4];

    logic [3:0]          win;
    logic [3:0]          lt_thr;
    logic [1:0]          pick;
    logic                hit_ok;
    logic [HIT_W-1:0]    r_hits;
    t_bridge             cand;

    logic                r_pv, n_pv;
    logic                r_pf, n_pf;
    t_bridge             r_pb, n_pb;
    logic                r_ov, n_ov;
    t_bridge             r_ob, n_ob;

    assign adv = !r_ov || i_bridge_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
        if (i_cmd.start) begin
            r_new <= i_seg;
        end
    end

    seb_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(i_cmd.wr_addr),
        .i_wdata(i_seg),
        .i_re   (i_cmd.issue),
        .i_raddr(i_cmd.rd_addr),
        .o_rdata(ram_rdata)
    );

    assign ram_q = ram_rdata;

    // endpoint pairs in pick order
    always_comb begin
        fx[0] = ram_q.sx; fy[0] = ram_q.sy; tx[0] = r_new.sx; ty[0] = r_new.sy;
        fx[1] = ram_q.sx; fy[1] = ram_q.sy; tx[1] = r_new.ex; ty[1] = r_new.ey;
        fx[2] = ram_q.ex; fy[2] = ram_q.ey; tx[2] = r_new.sx; ty[2] = r_new.sy;
        fx[3] = ram_q.ex; fy[3] = ram_q.ey; tx[3] = r_new.ex; ty[3] = r_new.ey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (adv) begin
            r_e0 <= i_cmd.rd_end;
            r_e1 <= r_e0;
            r_e2 <= r_e1;
            r_e3 <= r_e2;
            r_s1 <= ram_q;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            for (int k = 0; k < 4; k++) begin
                r_adx[k] <= abs_diff(fx[k], tx[k]);
                r_ady[k] <= abs_diff(fy[k], ty[k]);
                r_sqx[k] <= SQ_W'(r_adx[k]) * SQ_W'(r_adx[k]);
                r_sqy[k] <= SQ_W'(r_ady[k]) * SQ_W'(r_ady[k]);
                r_d[k]   <= DIST_W'(r_sqx[k]) + DIST_W'(r_sqy[k]);
            end
        end
    end

    // first strict minimum, valid only below the ceiling
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            win[k]    = (r_d[k] < DIST_W'(GAP_CEILING));
            lt_thr[k] = (r_d[k] < DIST_W'(r_thr));
            for (int j = 0; j < 4; j++) begin
                if (j < k) begin
                    win[k] = win[k] && (r_d[k] < r_d[j]);
                end else if (j > k) begin
                    win[k] = win[k] && (r_d[k] <= r_d[j]);
                end
            end
        end
        pick   = {win[2] | win[3], win[1] | win[3]};
        hit_ok = r_v3 && ((win & lt_thr) != 4'd0) && (r_hits < HIT_W'(MAX_RESULTS));
        cand.fx   = pick[1] ? r_s3.ex : r_s3.sx;
        cand.fy   = pick[1] ? r_s3.ey : r_s3.sy;
        cand.tx   = pick[0] ? r_new.ex : r_new.sx;
        cand.ty   = pick[0] ? r_new.ey : r_new.sy;
        cand.last = 1'b0;
    end

    // one bridge held back until it is known whether it is the last
    always_comb begin
        n_pv = r_pv;
        n_pf = r_pf;
        n_pb = r_pb;
        n_ov = r_ov;
        n_ob = r_ob;
        if (adv) begin
            n_ov = 1'b0;
            if (r_v3) begin
                if (hit_ok) begin
                    if (r_pv) begin
                        n_ov = 1'b1;
                        n_ob = r_pb;
                    end
                    n_pv = 1'b1;
                    n_pf = r_e3;
                    n_pb = cand;
                end else if (r_e3 && r_pv) begin
                    n_ov      = 1'b1;
                    n_ob      = r_pb;
                    n_ob.last = 1'b1;
                    n_pv      = 1'b0;
                end
            end else if (r_pv && r_pf) begin
                n_ov      = 1'b1;
                n_ob      = r_pb;
                n_ob.last = 1'b1;
                n_pv      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
            r_hits <= '0;
        end else begin
            r_pv <= n_pv;
            r_ov <= n_ov;
            if (i_cmd.start) begin
                r_hits <= '0;
            end else if (adv && hit_ok) begin
                r_hits <= r_hits + HIT_W'(1);
            end
        end
        r_pf <= n_pf;
        r_pb <= n_pb;
        r_ob <= n_ob;
    end

    assign o_stat.adv  = adv;
    assign o_stat.busy = r_v0 | r_v1 | r_v2 | r_v3 | r_pv;

    assign o_bridge_valid = r_ov;
    assign o_bridge       = r_ob;

endmodule

// ===== rtl/segment_endpoint_bridger_core.sv =====
// path: the bridge for each stored entry passes the store read and the difference, square
// and sum registers, enters a one-deep hold and is offered on the output at the next
// bridge or at the scan end; a new segment is taken only in idle, once the scan of the
// stored segments and the drain are done; the scan reads one stored segment per cycle
// while the output is not stalled
// reset: synchronous active low, empties the store and sets the gap threshold to 1440
// ----------------------------------------------------------------------------
// segment_endpoint_bridger_core
// bridges near endpoints of a new segment to each earlier segment within the gap threshold, up to 63 in the set
// ----------------------------------------------------------------------------
module segment_endpoint_bridger_core import seb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_wdata,
    input  logic                i_seg_valid,
    output logic                o_seg_ready,
    input  logic [COORD_BITS-1:0] i_seg_start_x,
    input  logic [COORD_BITS-1:0] i_seg_start_y,
    input  logic [COORD_BITS-1:0] i_seg_end_x,
    input  logic [COORD_BITS-1:0] i_seg_end_y,
    input  logic                i_new_set,
    output logic                o_bridge_valid,
    input  logic                i_bridge_ready,
    output logic [COORD_BITS-1:0] o_bridge_from_x,
    output logic [COORD_BITS-1:0] o_bridge_from_y,
    output logic [COORD_BITS-1:0] o_bridge_to_x,
    output logic [COORD_BITS-1:0] o_bridge_to_y,
    output logic                o_last_of_run
);

    t_cmd    cmd;
    t_stat   stat;
    t_seg    seg;
    t_bridge bridge;

    assign seg.sx = i_seg_start_x;
    assign seg.sy = i_seg_start_y;
    assign seg.ex = i_seg_end_x;
    assign seg.ey = i_seg_end_y;

    seb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg_valid(i_seg_valid),
        .o_seg_ready(o_seg_ready),
        .i_new_set  (i_new_set),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    seb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_seg         (seg),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_bridge_valid(o_bridge_valid),
        .i_bridge_ready(i_bridge_ready),
        .o_bridge      (bridge)
    );

    assign o_bridge_from_x = bridge.fx;
    assign o_bridge_from_y = bridge.fy;
    assign o_bridge_to_x   = bridge.tx;
    assign o_bridge_to_y   = bridge.ty;
    assign o_last_of_run   = bridge.last;

endmodule
